@@ src/baro_sensor_compensation_macros.svh @@
// Assertion macros for the barometric compensation block.
// Used by files that carry concurrent assertions; no other dependencies.
`ifndef BARO_SENSOR_COMPENSATION_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_MACROS_SVH

// condition holds in the same cycle
`define BSC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the following cycle
`define BSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/bsc_pkg.sv @@
// Types, codes and helpers for the barometric compensation block.
// No dependencies; used by bsc_mdu and baro_sensor_compensation.
`default_nettype none

package bsc_pkg;

   typedef struct packed {
      logic        operation;
      logic [19:0] raw_reading;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic signed [23:0] temperature_centi_degc;
      logic [31:0]        pressure_pa_q24_8;
      logic               divisor_zero;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic        is_div;
      logic [63:0] opa;
      logic [63:0] opb;
   } mdu_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] result;
   } mdu_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_WAIT  = 4'b0100,
      S_OUT   = 4'b1000
   } state_type;

   typedef enum logic [13:0] {
      ST_T_A   = 14'b00_0000_0000_0001,
      ST_T_D   = 14'b00_0000_0000_0010,
      ST_T_B   = 14'b00_0000_0000_0100,
      ST_P_SQ  = 14'b00_0000_0000_1000,
      ST_P_V2  = 14'b00_0000_0001_0000,
      ST_P_V5  = 14'b00_0000_0010_0000,
      ST_P_P3  = 14'b00_0000_0100_0000,
      ST_P_P2  = 14'b00_0000_1000_0000,
      ST_P_P1  = 14'b00_0001_0000_0000,
      ST_P_N   = 14'b00_0010_0000_0000,
      ST_P_DIV = 14'b00_0100_0000_0000,
      ST_P_S9  = 14'b00_1000_0000_0000,
      ST_P_SS  = 14'b01_0000_0000_0000,
      ST_P_P8  = 14'b10_0000_0000_0000
   } step_type;

   localparam logic [1:0] CSR_TCAL   = 2'd0;
   localparam logic [1:0] CSR_PCAL_A = 2'd1;
   localparam logic [1:0] CSR_PCAL_B = 2'd2;
   localparam logic [1:0] CSR_PCAL_C = 2'd3;

   localparam logic      OP_TEMP  = 1'b0;
   localparam logic      OP_PRESS = 1'b1;

   localparam logic [63:0] T_OFFSET   = 64'd128000;
   localparam logic [63:0] P_FULL     = 64'd1048576;
   localparam logic [63:0] P_SCALE    = 64'd3125;
   localparam logic [63:0] P_BIAS     = 64'd1 << 47;
   localparam logic [31:0] T_ROUND    = 32'd128;

   function automatic logic [63:0] sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] n);
      return 64'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
      return 32'($signed(x) >>> n);
   endfunction

endpackage

`default_nettype wire

@@ src/bsc_mdu.sv @@
// Iterative 64-bit multiply (low word) and unsigned divide, one bit per cycle.
// Depends on bsc_pkg for the command and response structs.
`default_nettype none

module bsc_mdu
   import bsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mdu_cmd_type cmd,
   output mdu_rsp_type      rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [64:0] rem_sh;
   logic [65:0] rem_diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      rem_sh   = {acc_ff, a_ff[63]};
      rem_diff = {1'b0, rem_sh} - {2'b00, b_ff};
      if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = cmd.is_div;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = cmd.opa;
         b_in    = cmd.opb;
      end else if (busy_ff) begin
         if (div_ff) begin
            if (!rem_diff[65]) begin
               acc_in = rem_diff[63:0];
               a_in   = {a_ff[62:0], 1'b1};
            end else begin
               acc_in = rem_sh[63:0];
               a_in   = {a_ff[62:0], 1'b0};
            end
         end else begin
            if (a_ff[0]) begin
               acc_in = acc_ff + b_ff;
            end
            a_in = {1'b0, a_ff[63:1]};
            b_in = {b_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         div_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         div_ff  <= div_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign rsp.busy   = busy_ff;
   assign rsp.done   = done_ff;
   assign rsp.result = div_ff ? a_ff : acc_ff;

endmodule

`default_nettype wire

@@ src/baro_sensor_compensation.sv @@
// Top level of the barometric compensation block: CSRs, sequencer, result register.
// Depends on bsc_pkg, bsc_mdu and baro_sensor_compensation_macros.svh.
//
//   channel  ports                          direction
//   req      req_valid/req_ready/req_data   in   raw reading and kind
//   rsp      rsp_valid/rsp_ready/rsp_data   out  compensated result
//   csr      csr_valid/csr_ready/csr_index/csr_wdata  in  calibration write
//
// Each unit operation is issued in S_ISSUE and then waited on in S_WAIT until the unit
// signals done. Temperature: 3 multiplies; pressure: 10 multiplies and one divide,
// all on the one bit-per-cycle unit, with pressure ending early on a zero divisor.
// One request at a time; req_ready is low from accept until the result is taken.
// Synchronous reset clears the calibration words and the fine temperature.
`default_nettype none

`include "baro_sensor_compensation_macros.svh"

module baro_sensor_compensation
   import bsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   state_type   state_ff, state_in;
   step_type    step_ff, step_in;
   logic [47:0] tcal_ff;
   logic [63:0] pcal_a_ff, pcal_b_ff;
   logic [15:0] pcal_c_ff;
   logic [31:0] ft_ff, ft_in;
   logic [19:0] raw_ff, raw_in;
   logic [31:0] ta_ff, ta_in, tb_ff, tb_in;
   logic [63:0] v1_ff, v1_in, sq_ff, sq_in, v2_ff, v2_in;
   logic [63:0] x_ff, x_in, den_ff, den_in, q_ff, q_in;
   rsp_type     rsp_ff, rsp_in;
   mdu_cmd_type cmd;
   mdu_rsp_type mrsp;
   logic [63:0] r, pdiff, qfix, fin, s13;
   logic [31:0] tb_new, ft_new, tout;
   logic [31:0] raw32, t1;

   bsc_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (mrsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   assign r     = mrsp.result;
   assign raw32 = {12'd0, raw_ff};
   assign t1    = {16'd0, tcal_ff[15:0]};
   assign pdiff = P_FULL - {44'd0, raw_ff};
   assign s13   = asr64(q_ff, 6'd13);

   always_comb begin
      cmd.start  = (state_ff == S_ISSUE);
      cmd.is_div = 1'b0;
      cmd.opa    = '0;
      cmd.opb    = '0;
      unique case (step_ff)
         ST_T_A: begin
            cmd.opa = {32'd0, (raw32 >> 3) - (t1 << 1)};
            cmd.opb = sx16(tcal_ff[31:16]);
         end
         ST_T_D: begin
            cmd.opa = {32'd0, (raw32 >> 4) - t1};
            cmd.opb = {32'd0, (raw32 >> 4) - t1};
         end
         ST_T_B: begin
            cmd.opa = {32'd0, tb_ff};
            cmd.opb = sx16(tcal_ff[47:32]);
         end
         ST_P_SQ: begin
            cmd.opa = v1_ff;
            cmd.opb = v1_ff;
         end
         ST_P_V2: begin
            cmd.opa = sq_ff;
            cmd.opb = sx16(pcal_b_ff[31:16]);
         end
         ST_P_V5: begin
            cmd.opa = v1_ff;
            cmd.opb = sx16(pcal_b_ff[15:0]);
         end
         ST_P_P3: begin
            cmd.opa = sq_ff;
            cmd.opb = sx16(pcal_a_ff[47:32]);
         end
         ST_P_P2: begin
            cmd.opa = v1_ff;
            cmd.opb = sx16(pcal_a_ff[31:16]);
         end
         ST_P_P1: begin
            cmd.opa = x_ff;
            cmd.opb = {48'd0, pcal_a_ff[15:0]};
         end
         ST_P_N: begin
            cmd.opa = (pdiff << 31) - v2_ff;
            cmd.opb = P_SCALE;
         end
         ST_P_DIV: begin
            cmd.is_div = 1'b1;
            cmd.opa    = sq_ff[63] ? (64'd0 - sq_ff) : sq_ff;
            cmd.opb    = den_ff[63] ? (64'd0 - den_ff) : den_ff;
         end
         ST_P_S9: begin
            cmd.opa = sx16(pcal_c_ff);
            cmd.opb = s13;
         end
         ST_P_SS: begin
            cmd.opa = v2_ff;
            cmd.opb = s13;
         end
         ST_P_P8: begin
            cmd.opa = sx16(pcal_b_ff[63:48]);
            cmd.opb = q_ff;
         end
         default: begin
            cmd.opa = '0;
            cmd.opb = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ft_in    = ft_ff;
      raw_in   = raw_ff;
      ta_in    = ta_ff;
      tb_in    = tb_ff;
      v1_in    = v1_ff;
      sq_in    = sq_ff;
      v2_in    = v2_ff;
      x_in     = x_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      rsp_in   = rsp_ff;
      tb_new   = asr32(r[31:0], 5'd14);
      ft_new   = ta_ff + tb_new;
      tout     = asr32((ft_new << 2) + ft_new + T_ROUND, 5'd8);
      qfix     = (sq_ff[63] != den_ff[63]) ? (64'd0 - r) : r;
      fin      = asr64(q_ff + x_ff + asr64(r, 6'd19), 6'd8) + (sx16(pcal_b_ff[47:32]) << 4);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               raw_in   = req_data.raw_reading;
               v1_in    = {{32{ft_ff[31]}}, ft_ff} - T_OFFSET;
               step_in  = (req_data.operation == OP_PRESS) ? ST_P_SQ : ST_T_A;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (mrsp.done) begin
               state_in = S_ISSUE;
               unique case (step_ff)
                  ST_T_A: begin
                     ta_in   = asr32(r[31:0], 5'd11);
                     step_in = ST_T_D;
                  end
                  ST_T_D: begin
                     tb_in   = asr32(r[31:0], 5'd12);
                     step_in = ST_T_B;
                  end
                  ST_T_B: begin
                     ft_in    = ft_new;
                     rsp_in   = '{result_kind: OP_TEMP, temperature_centi_degc: tout[23:0],
                                  pressure_pa_q24_8: 32'd0, divisor_zero: 1'b0};
                     state_in = S_OUT;
                  end
                  ST_P_SQ: begin
                     sq_in   = r;
                     step_in = ST_P_V2;
                  end
                  ST_P_V2: begin
                     v2_in   = r;
                     step_in = ST_P_V5;
                  end
                  ST_P_V5: begin
                     v2_in   = v2_ff + (r << 17) + (sx16(pcal_a_ff[63:48]) << 35);
                     step_in = ST_P_P3;
                  end
                  ST_P_P3: begin
                     x_in    = asr64(r, 6'd8);
                     step_in = ST_P_P2;
                  end
                  ST_P_P2: begin
                     x_in    = P_BIAS + x_ff + (r << 12);
                     step_in = ST_P_P1;
                  end
                  ST_P_P1: begin
                     den_in  = asr64(r, 6'd33);
                     step_in = ST_P_N;
                     if (asr64(r, 6'd33) == 64'd0) begin
                        rsp_in   = '{result_kind: OP_PRESS, temperature_centi_degc: 24'sd0,
                                     pressure_pa_q24_8: 32'd0, divisor_zero: 1'b1};
                        state_in = S_OUT;
                     end
                  end
                  ST_P_N: begin
                     sq_in   = r;
                     step_in = ST_P_DIV;
                  end
                  ST_P_DIV: begin
                     q_in    = qfix;
                     step_in = ST_P_S9;
                  end
                  ST_P_S9: begin
                     v2_in   = r;
                     step_in = ST_P_SS;
                  end
                  ST_P_SS: begin
                     x_in    = asr64(r, 6'd25);
                     step_in = ST_P_P8;
                  end
                  ST_P_P8: begin
                     rsp_in   = '{result_kind: OP_PRESS, temperature_centi_degc: 24'sd0,
                                  pressure_pa_q24_8: fin[31:0], divisor_zero: 1'b0};
                     state_in = S_OUT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         step_ff   <= ST_T_A;
         ft_ff     <= '0;
         tcal_ff   <= '0;
         pcal_a_ff <= '0;
         pcal_b_ff <= '0;
         pcal_c_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ft_ff    <= ft_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_TCAL:   tcal_ff   <= csr_wdata[47:0];
               CSR_PCAL_A: pcal_a_ff <= csr_wdata;
               CSR_PCAL_B: pcal_b_ff <= csr_wdata;
               CSR_PCAL_C: pcal_c_ff <= csr_wdata[15:0];
               default:    tcal_ff   <= tcal_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      raw_ff <= raw_in;
      ta_ff  <= ta_in;
      tb_ff  <= tb_in;
      v1_ff  <= v1_in;
      sq_ff  <= sq_in;
      v2_ff  <= v2_in;
      x_ff   <= x_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      rsp_ff <= rsp_in;
   end

   `BSC_ASSERT_SAME(a_start_idle_unit, clock, reset, cmd.start, !mrsp.busy, "unit started while busy")
   `BSC_ASSERT_NEXT(a_accept_blocks, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")
   `BSC_ASSERT_SAME(a_temp_fields, clock, reset, rsp_valid && !rsp_data.result_kind, rsp_data.pressure_pa_q24_8 == 32'd0 && !rsp_data.divisor_zero, "temperature result carries pressure")
   `BSC_ASSERT_SAME(a_zero_div, clock, reset, rsp_valid && rsp_data.divisor_zero, rsp_data.pressure_pa_q24_8 == 32'd0 && rsp_data.result_kind, "zero divisor with nonzero pressure")

endmodule

`default_nettype wire
